// ===== sv/bpdc_pkg.sv =====
// shared types, widths and constants for the button press duration classifier
`timescale 1ns / 1ps

package bpdc_pkg;

   // hold timer width
   localparam int TIME_WIDTH = 16;

   localparam int DEBOUNCE_WIDTH = 10;
   localparam int MS_WIDTH       = 16;
   localparam int SEC_WIDTH      = 7;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = 16;

   // common width for comparing the hold timer with the millisecond registers
   localparam int CMP_WIDTH = (TIME_WIDTH > MS_WIDTH) ? TIME_WIDTH : MS_WIDTH;

   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET  = DEBOUNCE_WIDTH'(50);
   localparam logic [MS_WIDTH-1:0]       NAV_MAX_RESET   = MS_WIDTH'(900);
   localparam logic [MS_WIDTH-1:0]       CD_START_RESET  = MS_WIDTH'(900);
   localparam logic [MS_WIDTH-1:0]       POWEROFF_RESET  = MS_WIDTH'(5000);

   localparam logic [DEBOUNCE_WIDTH-1:0] SAMPLE_MAX = '1;
   localparam logic [TIME_WIDTH-1:0]     TIME_MAX   = '1;

   // divide by 1000 as multiply by reciprocal, exact for numerators below 2^18
   localparam int NUM_WIDTH   = MS_WIDTH + 1;
   localparam int RECIP_SHIFT = 26;
   localparam int RECIP_WIDTH = 17;
   localparam logic [RECIP_WIDTH-1:0] RECIP_1000 = RECIP_WIDTH'(67109);
   localparam int PROD_WIDTH  = NUM_WIDTH + RECIP_WIDTH;
   localparam logic [NUM_WIDTH-1:0] ROUND_UP = NUM_WIDTH'(999);

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_DEBOUNCE = 3'd0,
      CSR_NAV_MAX  = 3'd1,
      CSR_CD_START = 3'd2,
      CSR_POWEROFF = 3'd3
   } csr_idx_type;

   typedef struct packed {
      logic [DEBOUNCE_WIDTH-1:0] debounce_ms;
      logic [MS_WIDTH-1:0]       nav_max_ms;
      logic [MS_WIDTH-1:0]       countdown_start_ms;
      logic [MS_WIDTH-1:0]       poweroff_ms;
   } cfg_type;

   typedef struct packed {
      logic pin_pressed;
      logic overlay_active;
   } req_type;

   typedef struct packed {
      logic                 nav_event;
      logic                 hide_overlay;
      logic                 countdown_show;
      logic [SEC_WIDTH-1:0] countdown_seconds;
      logic                 poweroff_event;
   } rsp_type;

endpackage

// ===== sv/bpdc_csr.sv =====
// configuration register file
`timescale 1ns / 1ps

module bpdc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bpdc_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [bpdc_pkg::CSR_DATA_WIDTH-1:0] csr_data,
   output bpdc_pkg::cfg_type                  cfg
);
   import bpdc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_DEBOUNCE: cfg_in.debounce_ms        = csr_data[DEBOUNCE_WIDTH-1:0];
            CSR_NAV_MAX:  cfg_in.nav_max_ms         = csr_data[MS_WIDTH-1:0];
            CSR_CD_START: cfg_in.countdown_start_ms = csr_data[MS_WIDTH-1:0];
            CSR_POWEROFF: cfg_in.poweroff_ms        = csr_data[MS_WIDTH-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms        <= DEBOUNCE_RESET;
         cfg_ff.nav_max_ms         <= NAV_MAX_RESET;
         cfg_ff.countdown_start_ms <= CD_START_RESET;
         cfg_ff.poweroff_ms        <= POWEROFF_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/bpdc_countdown.sv =====
// whole-second countdown value from hold time and power-off time
`timescale 1ns / 1ps

module bpdc_countdown (
   input  logic [bpdc_pkg::TIME_WIDTH-1:0] held,
   input  logic [bpdc_pkg::MS_WIDTH-1:0]   poweroff_ms,
   output logic                            reached,
   output logic [bpdc_pkg::SEC_WIDTH-1:0]  seconds
);
   import bpdc_pkg::*;

   logic [CMP_WIDTH-1:0]  held_ext;
   logic [CMP_WIDTH-1:0]  po_ext;
   logic [MS_WIDTH-1:0]   remain;
   logic [NUM_WIDTH-1:0]  num;
   logic [PROD_WIDTH-1:0] prod_secs;
   logic [PROD_WIDTH-1:0] prod_top;
   logic [SEC_WIDTH-1:0]  secs_ceil;
   logic [SEC_WIDTH-1:0]  secs_min;
   logic [SEC_WIDTH-1:0]  top;

   assign held_ext = CMP_WIDTH'(held);
   assign po_ext   = CMP_WIDTH'(poweroff_ms);
   assign reached  = held_ext >= po_ext;

   // below the power-off time the hold fits the millisecond width
   assign remain = poweroff_ms - held_ext[MS_WIDTH-1:0];
   assign num    = NUM_WIDTH'(remain) + ROUND_UP;

   assign prod_secs = PROD_WIDTH'(num) * PROD_WIDTH'(RECIP_1000);
   assign prod_top  = PROD_WIDTH'(poweroff_ms) * PROD_WIDTH'(RECIP_1000);
   assign secs_ceil = prod_secs[RECIP_SHIFT +: SEC_WIDTH];
   assign top       = prod_top[RECIP_SHIFT +: SEC_WIDTH];

   always_comb begin
      if (reached || secs_ceil == '0) begin
         secs_min = SEC_WIDTH'(1);
      end else begin
         secs_min = secs_ceil;
      end
      if (secs_min > top) begin
         seconds = top;
      end else begin
         seconds = secs_min;
      end
   end

endmodule

// ===== sv/bpdc_core.sv =====
// press state, sample timer and hold timer with the per-tick decision logic
`timescale 1ns / 1ps

module bpdc_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  bpdc_pkg::req_type   req,
   input  bpdc_pkg::cfg_type   cfg,
   output bpdc_pkg::rsp_type   rsp
);
   import bpdc_pkg::*;

   logic [DEBOUNCE_WIDTH-1:0] since_sample_ff, since_sample_in;
   logic                      button_down_ff,  button_down_in;
   logic [TIME_WIDTH-1:0]     held_time_ff,    held_time_in;
   logic                      poweroff_sent_ff, poweroff_sent_in;
   logic [SEC_WIDTH-1:0]      last_seconds_ff, last_seconds_in;

   logic [TIME_WIDTH-1:0]     held_inc;
   logic [DEBOUNCE_WIDTH-1:0] count;
   logic                      press_new;
   logic [TIME_WIDTH-1:0]     held_eff;
   logic                      sent_eff;
   logic [SEC_WIDTH-1:0]      last_eff;
   logic                      reached;
   logic [SEC_WIDTH-1:0]      seconds;

   bpdc_countdown u_countdown (
      .held        (held_eff),
      .poweroff_ms (cfg.poweroff_ms),
      .reached     (reached),
      .seconds     (seconds)
   );

   always_comb begin
      held_inc = held_time_ff;
      if (button_down_ff && held_time_ff != TIME_MAX) begin
         held_inc = held_time_ff + TIME_WIDTH'(1);
      end
      count = (since_sample_ff == SAMPLE_MAX) ? SAMPLE_MAX
                                              : since_sample_ff + DEBOUNCE_WIDTH'(1);
      press_new = req.pin_pressed && !button_down_ff;
      held_eff  = press_new ? '0   : held_inc;
      sent_eff  = press_new ? 1'b0 : poweroff_sent_ff;
      last_eff  = press_new ? '0   : last_seconds_ff;
   end

   always_comb begin
      since_sample_in  = '0;
      button_down_in   = button_down_ff | press_new;
      held_time_in     = held_eff;
      poweroff_sent_in = sent_eff;
      last_seconds_in  = last_eff;
      rsp              = '0;
      if (count < cfg.debounce_ms) begin
         // no sample this tick
         since_sample_in  = count;
         button_down_in   = button_down_ff;
         held_time_in     = held_inc;
         poweroff_sent_in = poweroff_sent_ff;
         last_seconds_in  = last_seconds_ff;
      end else if (!req.pin_pressed && button_down_ff) begin
         rsp.hide_overlay = req.overlay_active;
         rsp.nav_event    = !req.overlay_active &&
                            (CMP_WIDTH'(held_inc) < CMP_WIDTH'(cfg.nav_max_ms));
         button_down_in   = 1'b0;
         held_time_in     = '0;
         last_seconds_in  = '0;
      end else if (req.pin_pressed && !sent_eff &&
                   CMP_WIDTH'(held_eff) >= CMP_WIDTH'(cfg.countdown_start_ms)) begin
         if (seconds != last_eff) begin
            rsp.countdown_show    = 1'b1;
            rsp.countdown_seconds = seconds;
            last_seconds_in       = seconds;
         end
         if (reached) begin
            rsp.poweroff_event = 1'b1;
            poweroff_sent_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         since_sample_ff  <= '0;
         button_down_ff   <= 1'b0;
         held_time_ff     <= '0;
         poweroff_sent_ff <= 1'b0;
         last_seconds_ff  <= '0;
      end else if (fire) begin
         since_sample_ff  <= since_sample_in;
         button_down_ff   <= button_down_in;
         held_time_ff     <= held_time_in;
         poweroff_sent_ff <= poweroff_sent_in;
         last_seconds_ff  <= last_seconds_in;
      end
   end

endmodule

// ===== sv/button_press_duration_classifier_top.sv =====
// top level: request register, classifier core, result register, configuration
`timescale 1ns / 1ps

// channel   direction  handshake          payload
// req_      in         req_valid/stall    pin_pressed, overlay_active
// rsp_      out        rsp_valid/stall    nav_event, hide_overlay, countdown_show,
//                                         countdown_seconds, poweroff_event
// csr_      in         csr_valid/ready    csr_index, csr_data
//
// one request per cycle while req_stall is low; the accepting edge loads the request register,
// and the result register loads from it once the result register is free or being emptied
// reset is synchronous and clears the valid flags, core state and configuration; the button returns to released
// a stalled result holds; requests are still taken while the request stage is free
// csr writes always complete in the cycle they are presented

module button_press_duration_classifier_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_pin_pressed,
   input  logic                               req_overlay_active,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_nav_event,
   output logic                               rsp_hide_overlay,
   output logic                               rsp_countdown_show,
   output logic [bpdc_pkg::SEC_WIDTH-1:0]      rsp_countdown_seconds,
   output logic                               rsp_poweroff_event,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bpdc_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [bpdc_pkg::CSR_DATA_WIDTH-1:0] csr_data
);
   import bpdc_pkg::*;

   cfg_type cfg;
   req_type req_ff;
   rsp_type rsp_ff;
   rsp_type rsp_calc;
   logic    req_valid_ff;
   logic    rsp_valid_ff;
   logic    advance;
   logic    fire;

   bpdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bpdc_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (req_ff),
      .cfg   (cfg),
      .rsp   (rsp_calc)
   );

   // result register free or being emptied this cycle
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= req_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff.pin_pressed    <= req_pin_pressed;
         req_ff.overlay_active <= req_overlay_active;
      end
      if (fire) begin
         rsp_ff <= rsp_calc;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_nav_event         = rsp_ff.nav_event;
   assign rsp_hide_overlay      = rsp_ff.hide_overlay;
   assign rsp_countdown_show    = rsp_ff.countdown_show;
   assign rsp_countdown_seconds = rsp_ff.countdown_seconds;
   assign rsp_poweroff_event    = rsp_ff.poweroff_event;

endmodule

// ===== test/button_press_duration_classifier_top_tb.sv =====
// self-checking testbench for the button press duration classifier top level
`timescale 1ns / 1ps

module button_press_duration_classifier_top_tb;

   import bpdc_pkg::*;

   localparam int CLK_PERIOD     = 8;
   localparam int RESET_CYCLES   = 10;
   localparam int IDLE_LIMIT     = 2000;
   localparam int HOLDOFF_CYCLES = 200;
   localparam int SETTLE_CYCLES  = 6;
   localparam int TAIL_CYCLES    = 20;
   localparam int RANDOM_ITEMS   = 380;
   localparam int PHASE_ITEMS    = 80;
   localparam int MS_PER_SEC     = 1000;
   localparam int MS_ROUND_UP    = 999;

   typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_mode_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_pin_pressed = 1'b0;
   logic                      req_overlay_active = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_nav_event;
   logic                      rsp_hide_overlay;
   logic                      rsp_countdown_show;
   logic [SEC_WIDTH-1:0]      rsp_countdown_seconds;
   logic                      rsp_poweroff_event;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_WIDTH-1:0]  csr_index = CSR_DEBOUNCE;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;

   // predictor state and its copy of the registers
   cfg_type                   live_cfg;
   logic [DEBOUNCE_WIDTH-1:0] tick_count;
   logic                      btn_held;
   logic [TIME_WIDTH-1:0]     hold_ms;
   logic                      off_sent;
   logic [SEC_WIDTH-1:0]      shown_secs;

   rsp_type     expected_rsp[$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   int          burst_left = 0;
   int          random_items = 0;
   int          holdoff_left = 0;
   logic        holdoff_start = 1'b0;
   int          rx_window = 0;
   rx_mode_type rx_mode = RX_FREE;

   button_press_duration_classifier_top i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_pin_pressed       (req_pin_pressed),
      .req_overlay_active    (req_overlay_active),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_nav_event         (rsp_nav_event),
      .rsp_hide_overlay      (rsp_hide_overlay),
      .rsp_countdown_show    (rsp_countdown_show),
      .rsp_countdown_seconds (rsp_countdown_seconds),
      .rsp_poweroff_event    (rsp_poweroff_event),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // one millisecond tick: advance the predictor and return the expected result
   function automatic rsp_type classify_tick(input logic pressed, input logic overlay);
      rsp_type     r;
      int unsigned cnt;
      int unsigned held;
      int unsigned pwr;
      int unsigned secs;
      int unsigned top;
      r = '0;
      if (btn_held && hold_ms != TIME_MAX) begin
         hold_ms = hold_ms + 1'b1;
      end
      cnt = tick_count + 1;
      if (cnt > SAMPLE_MAX) begin
         cnt = SAMPLE_MAX;
      end
      if (cnt < live_cfg.debounce_ms) begin
         tick_count = DEBOUNCE_WIDTH'(cnt);
         return r;
      end
      tick_count = '0;
      if (pressed && !btn_held) begin
         btn_held   = 1'b1;
         hold_ms    = '0;
         off_sent   = 1'b0;
         shown_secs = '0;
      end
      if (!pressed && btn_held) begin
         if (overlay) begin
            r.hide_overlay = 1'b1;
         end else if (hold_ms < live_cfg.nav_max_ms) begin
            r.nav_event = 1'b1;
         end
         btn_held   = 1'b0;
         hold_ms    = '0;
         shown_secs = '0;
         return r;
      end
      if (!pressed || off_sent) begin
         return r;
      end
      held = hold_ms;
      pwr  = live_cfg.poweroff_ms;
      if (held < live_cfg.countdown_start_ms) begin
         return r;
      end
      // at or past the power-off time the count is one second, before the clamp to the top
      if (held >= pwr) begin
         secs = 1;
      end else begin
         secs = (pwr - held + MS_ROUND_UP) / MS_PER_SEC;
      end
      if (secs < 1) begin
         secs = 1;
      end
      top = pwr / MS_PER_SEC;
      if (secs > top) begin
         secs = top;
      end
      if (secs != shown_secs) begin
         shown_secs          = SEC_WIDTH'(secs);
         r.countdown_show    = 1'b1;
         r.countdown_seconds = SEC_WIDTH'(secs);
      end
      if (held >= pwr) begin
         r.poweroff_event = 1'b1;
         off_sent         = 1'b1;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // predict on accepted requests, check accepted results against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_rsp.push_back(classify_tick(req_pin_pressed, req_overlay_active));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("result with no request pending", 1, 0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_nav_event !== want.nav_event)
                  report_mismatch("nav_event", rsp_nav_event, want.nav_event);
               if (rsp_hide_overlay !== want.hide_overlay)
                  report_mismatch("hide_overlay", rsp_hide_overlay, want.hide_overlay);
               if (rsp_countdown_show !== want.countdown_show)
                  report_mismatch("countdown_show", rsp_countdown_show, want.countdown_show);
               if (rsp_countdown_seconds !== want.countdown_seconds)
                  report_mismatch("countdown_seconds", rsp_countdown_seconds,
                                  want.countdown_seconds);
               if (rsp_poweroff_event !== want.poweroff_event)
                  report_mismatch("poweroff_event", rsp_poweroff_event, want.poweroff_event);
            end
         end
      end
   end

   // watchdog on cycles where no handshake of any kind completes
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver stall pattern, with an optional long hold-off
   always @(negedge clock) begin
      if (holdoff_start) begin
         holdoff_left  = HOLDOFF_CYCLES;
         holdoff_start = 1'b0;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (rx_window == 0) begin
            rx_mode   = rx_mode_type'($urandom_range(0, 2));
            rx_window = $urandom_range(8, 64);
         end
         rx_window--;
         case (rx_mode)
            RX_FREE:   rsp_stall <= 1'b0;
            RX_RANDOM: rsp_stall <= ($urandom_range(0, 99) < 35);
            default:   rsp_stall <= (rx_window % 3 == 0);
         endcase
      end
   end

   // offer one tick; the sender runs in bursts with random gaps between them
   task automatic send_tick(input logic pressed, input logic overlay);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         if ($urandom_range(0, 19) == 0) begin
            gap = $urandom_range(10, 30);
         end else if ($urandom_range(0, 3) == 0) begin
            gap = 0;
         end else begin
            gap = $urandom_range(1, 4);
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid          <= 1'b1;
      req_pin_pressed    <= pressed;
      req_overlay_active <= overlay;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic send_run(input int n, input logic pressed, input int overlay_pct);
      repeat (n) send_tick(pressed, $urandom_range(0, 99) < overlay_pct);
   endtask

   // stop offering and wait until every predicted result has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic apply_config(input int unsigned deb, input int unsigned nav,
                               input int unsigned start, input int unsigned off);
      cfg_type                   target_cfg;
      csr_idx_type               idx;
      logic [CSR_DATA_WIDTH-1:0] data;
      target_cfg.debounce_ms        = DEBOUNCE_WIDTH'(deb);
      target_cfg.nav_max_ms         = MS_WIDTH'(nav);
      target_cfg.countdown_start_ms = MS_WIDTH'(start);
      target_cfg.poweroff_ms        = MS_WIDTH'(off);
      drain();
      for (int i = CSR_DEBOUNCE; i <= CSR_POWEROFF; i++) begin
         idx = csr_idx_type'(i);
         case (idx)
            CSR_DEBOUNCE: data = CSR_DATA_WIDTH'(target_cfg.debounce_ms);
            CSR_NAV_MAX:  data = target_cfg.nav_max_ms;
            CSR_CD_START: data = target_cfg.countdown_start_ms;
            default:      data = target_cfg.poweroff_ms;
         endcase
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= data;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      // nothing is in flight, so the whole set can take effect at once
      live_cfg = target_cfg;
   endtask

   // default registers: slow sampling and a short press gives navigation
   task automatic test_reset_defaults();
      send_run(55, 1'b1, 0);
      send_run(55, 1'b0, 0);
   endtask

   task automatic test_release_kinds();
      apply_config(1, 4, 65535, 65535);
      send_run(2, 1'b1, 0);
      send_tick(1'b0, 1'b0);
      send_run(6, 1'b1, 50);
      send_tick(1'b0, 1'b0);
      send_run(2, 1'b1, 0);
      send_tick(1'b0, 1'b1);
      send_run(3, 1'b0, 100);
      // zero limit never gives navigation, full limit gives it for this short press
      apply_config(1, 0, 65535, 65535);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      apply_config(1, 65535, 65535, 65535);
      send_run(3, 1'b1, 0);
      send_tick(1'b0, 1'b0);
   endtask

   // level changes between samples must go unseen
   task automatic test_sampling();
      apply_config(4, 65535, 65535, 65535);
      repeat (3) begin
         send_tick(1'b1, 1'b0);
         send_run(2, 1'b0, 0);
      end
      send_run(8, 1'b1, 0);
      send_run(8, 1'b0, 0);
   endtask

   task automatic test_countdown_and_poweroff();
      // countdown from the press itself, clamped to the whole seconds available
      apply_config(1, 900, 0, 2500);
      send_run(30, 1'b1, 20);
      send_tick(1'b0, 1'b1);
      // countdown first shown once the start time is passed
      apply_config(2, 900, 10, 3999);
      send_run(40, 1'b1, 20);
      send_run(3, 1'b0, 0);
      // power-off time under one second: countdown clamps to zero, power-off once
      apply_config(1, 900, 0, 40);
      send_run(60, 1'b1, 20);
      send_tick(1'b0, 1'b0);
      // start beyond the power-off time: overshoot case
      apply_config(3, 900, 60, 30);
      send_run(80, 1'b1, 20);
      send_run(4, 1'b0, 0);
   endtask

   task automatic test_backpressure();
      apply_config(1, 20, 10, 1000);
      @(posedge clock);
      holdoff_start = 1'b1;
      @(negedge clock);
      send_run(15, 1'b1, 30);
      send_run(5, 1'b0, 30);
      send_run(15, 1'b1, 30);
      send_run(5, 1'b0, 30);
      // sender waits for every result before going on
      drain();
      send_run(12, 1'b1, 0);
      send_run(8, 1'b0, 0);
      drain();
   endtask

   task automatic test_random();
      int unsigned deb;
      int unsigned nav;
      int unsigned start;
      int unsigned off;
      int          phase_items;
      int          pick;
      int          n;
      int          m;
      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         deb  = (pick < 6) ? $urandom_range(1, 3) : (pick < 9) ? $urandom_range(4, 12) : 1;
         pick = $urandom_range(0, 9);
         nav  = (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(0, 20 * deb);
         pick = $urandom_range(0, 9);
         start = (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(0, 30 * deb);
         off  = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 150)
                                            : $urandom_range(1000, 2999);
         apply_config(deb, nav, start, off);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               n = $urandom_range(1, 12 * deb);
               m = $urandom_range(1, 4 * deb);
               send_run(n, 1'b1, 30);
               send_run(m, 1'b0, 30);
               phase_items += n + m;
            end else if (pick < 9) begin
               n = $urandom_range(4, 20);
               repeat (n) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
               phase_items += n;
            end else begin
               send_tick(1'b1, 1'($urandom_range(0, 1)));
               send_tick(1'b0, 1'($urandom_range(0, 1)));
               phase_items += 2;
            end
         end
         random_items += phase_items;
         // now and then a hold long enough to reach a short power-off time
         if (off < MS_PER_SEC && $urandom_range(0, 1) == 0) begin
            n = int'(off + deb + $urandom_range(0, 20));
            m = int'(2 * deb + 1);
            send_run(n, 1'b1, 30);
            send_run(m, 1'b0, 50);
            random_items += n + m;
         end
      end
   endtask

   initial begin
      live_cfg.debounce_ms        = DEBOUNCE_RESET;
      live_cfg.nav_max_ms         = NAV_MAX_RESET;
      live_cfg.countdown_start_ms = CD_START_RESET;
      live_cfg.poweroff_ms        = POWEROFF_RESET;
      tick_count = '0;
      btn_held   = 1'b0;
      hold_ms    = '0;
      off_sent   = 1'b0;
      shown_secs = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_defaults();
      test_release_kinds();
      test_sampling();
      test_countdown_and_poweroff();
      test_backpressure();
      test_random();
      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
